### src/two_channel_period_frequency_meter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frequency meter RTL.
// ----------------------------------------------------------------------------
`ifndef TWO_CHANNEL_PERIOD_FREQUENCY_METER_ASSERT_SVH
`define TWO_CHANNEL_PERIOD_FREQUENCY_METER_ASSERT_SVH

// Check a property at every clock edge outside reset
`define TCPFM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define TCPFM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/tcpfm_pkg.sv
// ----------------------------------------------------------------------------
// tcpfm_pkg
// Widths, register indexes, reset values and state codes of the meter.
// ----------------------------------------------------------------------------
package tcpfm_pkg;

    // Field and register widths
    localparam int DATA_W      = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int TIMER_W_DEF = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_SCALE  = CFG_IDX_W'(1);

    // Register reset values
    localparam logic [DATA_W-1:0] WRAP_LENGTH_RST = DATA_W'(99999);
    localparam logic [DATA_W-1:0] FREQ_SCALE_RST  = DATA_W'(1000000);

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SUB,
        S_WRAP,
        S_DIV,
        S_ZERO
    } t_state;

endpackage

### src/tcpfm_if.sv
// ----------------------------------------------------------------------------
// tcpfm_if
// Valid/ready channels for edge events and frequency results.
// ----------------------------------------------------------------------------
interface tcpfm_in_if;
    import tcpfm_pkg::*;

    logic              valid;
    logic              ready;
    logic              channel;
    logic [DATA_W-1:0] timer_value;

    modport source (output valid, output channel, output timer_value, input ready);
    modport sink   (input valid, input channel, input timer_value, output ready);
endinterface

interface tcpfm_out_if;
    import tcpfm_pkg::*;

    logic              valid;
    logic              ready;
    logic              out_channel;
    logic [DATA_W-1:0] frequency;
    logic              zero_duration;

    modport source (output valid, output out_channel, output frequency,
                    output zero_duration, input ready);
    modport sink   (input valid, input out_channel, input frequency,
                    input zero_duration, output ready);
endinterface

### src/tcpfm_div.sv
// ----------------------------------------------------------------------------
// tcpfm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "two_channel_period_frequency_meter_assert.svh"

module tcpfm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tcpfm_pkg::DATA_W-1:0] i_dividend,
    input  logic [tcpfm_pkg::DATA_W-1:0] i_divisor,
    output logic                        o_busy,
    output logic [tcpfm_pkg::DATA_W-1:0] o_quotient
);
    import tcpfm_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic [DATA_W-1:0] r_rem, n_rem;
    logic [DATA_W-1:0] r_quo, n_quo;
    logic [DATA_W-1:0] r_dvs;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;

    logic [DATA_W:0]   shifted;
    logic [DATA_W+1:0] trial;

    // Shift the next dividend bit into the remainder and try the subtract
    always_comb begin
        shifted = {r_rem, r_quo[DATA_W-1]};
        trial   = {1'b0, shifted} - {2'b00, r_dvs};
        if (!trial[DATA_W+1]) begin
            n_rem = trial[DATA_W-1:0];
            n_quo = {r_quo[DATA_W-2:0], 1'b1};
        end else begin
            n_rem = shifted[DATA_W-1:0];
            n_quo = {r_quo[DATA_W-2:0], 1'b0};
        end
    end

    // Control: count the quotient bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DATA_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath: load operands, then advance one bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

    `TCPFM_ASSERT(a_no_restart, i_clk, i_rst_n, !(i_start && r_busy),
        "divider started while busy")
    `TCPFM_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start, r_busy,
        "divider not busy after start")
    `TCPFM_ASSERT(a_full_count, i_clk, i_rst_n, !$fell(r_busy) || ($past(r_cnt) == '0),
        "divider finished before all quotient bits")

endmodule

### src/two_channel_period_frequency_meter.sv
// Sequence: an arming edge gives no beat; a finishing edge goes through the subtract state,
// the wrap state when its end time is not greater, then the divide or the zero state.
// Throughput: arming edges one per cycle while idle; a finishing edge holds off new edges
// until its result beat is loaded; the bit-serial divider spends one cycle per quotient bit.
// Reset: synchronous, active low; both channels go idle and the registers take their
// defaults at once, with no clearing pass.
// ----------------------------------------------------------------------------
// two_channel_period_frequency_meter
// Reciprocal frequency meter for two channels with a shared serial divider.
// ----------------------------------------------------------------------------
`include "two_channel_period_frequency_meter_assert.svh"

module two_channel_period_frequency_meter #(
    parameter int TIMER_WIDTH = tcpfm_pkg::TIMER_W_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tcpfm_in_if.sink                       i_in,
    tcpfm_out_if.source                    o_out,
    input  logic                           i_cfg_we,
    input  logic [tcpfm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tcpfm_pkg::DATA_W-1:0]    i_cfg_data
);
    import tcpfm_pkg::*;

    t_state r_state, n_state;

    logic [DATA_W-1:0]      r_wrap;
    logic [DATA_W-1:0]      r_scale;
    logic                   r_armed [2];
    logic [TIMER_WIDTH-1:0] r_start [2];
    logic [TIMER_WIDTH-1:0] r_t;
    logic                   r_ch;
    logic [DATA_W-1:0]      r_dur;

    logic                   r_out_valid;
    logic                   r_out_ch;
    logic [DATA_W-1:0]      r_out_freq;
    logic                   r_out_zero;

    logic              in_fire;
    logic              in_ready;
    logic              out_free;
    logic              out_load;
    logic [DATA_W-1:0] out_freq;
    logic              out_zero;
    logic [DATA_W:0]   diff;
    logic              gt;
    logic [DATA_W-1:0] wrap_sum;
    logic              div_start;
    logic [DATA_W-1:0] div_divisor;
    logic              div_busy;
    logic [DATA_W-1:0] div_quo;

    assign in_fire  = i_in.valid && in_ready;
    assign out_free = !r_out_valid || o_out.ready;

    // Duration: end minus start, flag when end is greater
    assign diff     = {1'b0, DATA_W'(r_t)} - {1'b0, DATA_W'(r_start[r_ch])};
    assign gt       = !diff[DATA_W] && (diff[DATA_W-1:0] != '0);
    assign wrap_sum = r_wrap + r_dur;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire && r_armed[i_in.channel]) begin
                    n_state = S_SUB;
                end
            end
            S_SUB: begin
                n_state = gt ? S_DIV : S_WRAP;
            end
            S_WRAP: begin
                n_state = (wrap_sum == '0) ? S_ZERO : S_DIV;
            end
            S_DIV: begin
                if (!div_busy && out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_ZERO: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        in_ready    = 1'b0;
        div_start   = 1'b0;
        div_divisor = wrap_sum;
        out_load    = 1'b0;
        out_freq    = div_quo;
        out_zero    = 1'b0;
        case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
            end
            S_SUB: begin
                div_start   = gt;
                div_divisor = diff[DATA_W-1:0];
            end
            S_WRAP: begin
                div_start = (wrap_sum != '0);
            end
            S_DIV: begin
                out_load = !div_busy && out_free;
            end
            S_ZERO: begin
                out_load = out_free;
                out_freq = '1;
                out_zero = 1'b1;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Control registers: state, arm flags, output valid, configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_armed[0]  <= 1'b0;
            r_armed[1]  <= 1'b0;
            r_out_valid <= 1'b0;
            r_wrap      <= WRAP_LENGTH_RST;
            r_scale     <= FREQ_SCALE_RST;
        end else begin
            r_state <= n_state;
            if (in_fire) begin
                r_armed[i_in.channel] <= !r_armed[i_in.channel];
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WRAP_LENGTH: r_wrap  <= i_cfg_data;
                    REG_FREQ_SCALE:  r_scale <= i_cfg_data;
                    default:         r_wrap  <= r_wrap;
                endcase
            end
        end
    end

    // Payload: capture edge time, hold duration, load result beat
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ch <= i_in.channel;
            r_t  <= i_in.timer_value[TIMER_WIDTH-1:0];
            if (!r_armed[i_in.channel]) begin
                r_start[i_in.channel] <= i_in.timer_value[TIMER_WIDTH-1:0];
            end
        end
        if (r_state == S_SUB) begin
            r_dur <= diff[DATA_W-1:0];
        end
        if (out_load) begin
            r_out_ch   <= r_ch;
            r_out_freq <= out_freq;
            r_out_zero <= out_zero;
        end
    end

    tcpfm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_scale),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    assign i_in.ready          = in_ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.out_channel   = r_out_ch;
    assign o_out.frequency     = r_out_freq;
    assign o_out.zero_duration = r_out_zero;

    `TCPFM_ASSERT_NEXT(a_finish_disarms, i_clk, i_rst_n,
        in_fire && r_armed[i_in.channel], (r_state == S_SUB) && !r_armed[r_ch],
        "finishing edge did not disarm its channel")
    `TCPFM_ASSERT_NEXT(a_start_div, i_clk, i_rst_n, div_start,
        (r_state == S_DIV) && div_busy, "divider start without divide state")
    `TCPFM_ASSERT(a_beat_source, i_clk, i_rst_n,
        !$rose(r_out_valid) || ($past(r_state) == S_DIV) || ($past(r_state) == S_ZERO),
        "result beat raised outside a finishing state")

endmodule
